// ===== rtl/gpio_eip_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpio_eip_pkg
// Register map, item codes and lane helpers for the GPIO edge interrupt port.
// ----------------------------------------------------------------------------
package gpio_eip_pkg;

    localparam logic [31:0] ID_VALUE = 32'h4483_0105;

    // item kinds
    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_PIN   = 2'd2;

    // set/clear notice kinds
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_SET   = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    // word-aligned register offsets
    localparam logic [7:0] OFF_ID        = 8'h00;
    localparam logic [7:0] OFF_PERIPH    = 8'h04;
    localparam logic [7:0] OFF_BANK_IRQ  = 8'h08;
    localparam logic [7:0] OFF_DIR       = 8'h10;
    localparam logic [7:0] OFF_OUT       = 8'h14;
    localparam logic [7:0] OFF_SET       = 8'h18;
    localparam logic [7:0] OFF_CLR       = 8'h1C;
    localparam logic [7:0] OFF_PINS      = 8'h20;
    localparam logic [7:0] OFF_RISE_SET  = 8'h24;
    localparam logic [7:0] OFF_RISE_CLR  = 8'h28;
    localparam logic [7:0] OFF_FALL_SET  = 8'h2C;
    localparam logic [7:0] OFF_FALL_CLR  = 8'h30;

    // byte mask of an access, before lane placement
    function automatic logic [31:0] size_mask(input logic [2:0] bytes);
        logic [31:0] m;
        case (bytes)
            3'd1:    m = 32'h0000_00FF;
            3'd2:    m = 32'h0000_FFFF;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage

// ===== rtl/gpio_edge_interrupt_port_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpio_edge_interrupt_port_unit
// 32-pin GPIO register block with per-pin rising/falling edge interrupts.
// ----------------------------------------------------------------------------
// Each accepted item (bus read, bus write, or external pin level change)
// produces exactly one result. The block takes one item every cycle while
// the output register is not held by a stall: the item is captured in an
// input register, evaluated against the register state by a single pass of
// 32-bit mask logic, and the result is placed in an output register while
// the state is updated on the same edge. The next item therefore sees the
// state left by the previous one. Input stall rises only when the output
// register is full and stalled downstream.
module gpio_edge_interrupt_port_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_offset,
    input  logic [2:0]  i_access_bytes,
    input  logic [31:0] i_write_data,
    input  logic [4:0]  i_pin_index,
    input  logic        i_pin_level,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_read_data,
    output logic        o_unmapped,
    output logic [31:0] o_setclr_mask,
    output logic [1:0]  o_setclr_kind,
    output logic [31:0] o_drive_change_mask,
    output logic [31:0] o_driven_levels,
    output logic [31:0] o_irq_pulse_mask,
    output logic [31:0] o_pin_levels
);

    // input register
    logic        r_in_valid;
    logic [1:0]  r_mode;
    logic [7:0]  r_offset;
    logic [2:0]  r_access_bytes;
    logic [31:0] r_write_data;
    logic [4:0]  r_pin_index;
    logic        r_pin_level;

    // register state
    logic [31:0] r_periph_ctrl,     n_periph_ctrl;
    logic [31:0] r_bank_irq_enable, n_bank_irq_enable;
    logic [31:0] r_direction,       n_direction;
    logic [31:0] r_output_value,    n_output_value;
    logic [31:0] r_rise_trigger,    n_rise_trigger;
    logic [31:0] r_fall_trigger,    n_fall_trigger;
    logic [31:0] r_external_levels, n_external_levels;
    logic [31:0] r_previous_pins,   n_previous_pins;

    // result register
    logic        r_out_valid;
    logic [31:0] r_read_data,         n_read_data;
    logic        r_unmapped,          n_unmapped;
    logic [31:0] r_setclr_mask,       n_setclr_mask;
    logic [1:0]  r_setclr_kind,       n_setclr_kind;
    logic [31:0] r_drive_change_mask, n_drive_change_mask;
    logic [31:0] r_driven_levels,     n_driven_levels;
    logic [31:0] r_irq_pulse_mask,    n_irq_pulse_mask;
    logic [31:0] r_pin_levels,        n_pin_levels;

    logic        w_out_ready;
    logic        w_advance;
    logic [7:0]  w_reg_off;
    logic [4:0]  w_shift;
    logic [31:0] w_size_mask;
    logic [31:0] w_lane_mask;
    logic [31:0] w_lane_data;
    logic [31:0] w_prior_driven;
    logic [31:0] w_outputs;
    logic [31:0] w_new_driven;
    logic [31:0] w_new_pins;
    logic [31:0] w_rise;
    logic [31:0] w_fall;
    logic [31:0] w_read_value;
    logic        w_update;

    assign w_out_ready = !r_out_valid || !i_out_stall;
    assign w_advance   = r_in_valid && w_out_ready;
    assign o_in_stall  = r_in_valid && !w_out_ready;

    assign w_reg_off   = {r_offset[7:2], 2'b00};
    assign w_shift     = {r_offset[1:0], 3'b000};
    assign w_size_mask = gpio_eip_pkg::size_mask(r_access_bytes);
    assign w_lane_mask = w_size_mask << w_shift;
    assign w_lane_data = (r_write_data << w_shift) & w_lane_mask;
    assign w_prior_driven = r_output_value & ~r_direction;

    // read mux and state writes
    always_comb begin
        n_periph_ctrl     = r_periph_ctrl;
        n_bank_irq_enable = r_bank_irq_enable;
        n_direction       = r_direction;
        n_output_value    = r_output_value;
        n_rise_trigger    = r_rise_trigger;
        n_fall_trigger    = r_fall_trigger;
        n_external_levels = r_external_levels;
        n_setclr_mask     = 32'h0;
        n_setclr_kind     = gpio_eip_pkg::KIND_NONE;
        n_unmapped        = 1'b0;
        w_read_value      = 32'h0;
        w_update          = 1'b0;
        case (r_mode)
            gpio_eip_pkg::MODE_READ: begin
                case (w_reg_off)
                    gpio_eip_pkg::OFF_ID:       w_read_value = gpio_eip_pkg::ID_VALUE;
                    gpio_eip_pkg::OFF_PERIPH:   w_read_value = r_periph_ctrl;
                    gpio_eip_pkg::OFF_BANK_IRQ: w_read_value = r_bank_irq_enable;
                    gpio_eip_pkg::OFF_DIR:      w_read_value = r_direction;
                    gpio_eip_pkg::OFF_OUT,
                    gpio_eip_pkg::OFF_SET,
                    gpio_eip_pkg::OFF_CLR:      w_read_value = r_output_value;
                    gpio_eip_pkg::OFF_PINS: begin
                        w_read_value = w_prior_driven | (r_external_levels & r_direction);
                    end
                    gpio_eip_pkg::OFF_RISE_SET,
                    gpio_eip_pkg::OFF_RISE_CLR: w_read_value = r_rise_trigger;
                    gpio_eip_pkg::OFF_FALL_SET,
                    gpio_eip_pkg::OFF_FALL_CLR: w_read_value = r_fall_trigger;
                    default:                    n_unmapped = 1'b1;
                endcase
            end
            gpio_eip_pkg::MODE_WRITE: begin
                w_update = 1'b1;
                case (w_reg_off)
                    gpio_eip_pkg::OFF_PERIPH: begin
                        n_periph_ctrl = (r_periph_ctrl & ~w_lane_mask) | w_lane_data;
                    end
                    gpio_eip_pkg::OFF_BANK_IRQ: begin
                        n_bank_irq_enable = (r_bank_irq_enable & ~w_lane_mask) | w_lane_data;
                    end
                    gpio_eip_pkg::OFF_DIR: begin
                        n_direction = (r_direction & ~w_lane_mask) | w_lane_data;
                    end
                    gpio_eip_pkg::OFF_OUT: begin
                        n_output_value = (r_output_value & ~w_lane_mask) | w_lane_data;
                    end
                    gpio_eip_pkg::OFF_SET: begin
                        n_output_value = r_output_value | w_lane_data;
                        n_setclr_mask  = w_lane_data;
                        n_setclr_kind  = gpio_eip_pkg::KIND_SET;
                    end
                    gpio_eip_pkg::OFF_CLR: begin
                        n_output_value = r_output_value & ~w_lane_data;
                        n_setclr_mask  = w_lane_data;
                        n_setclr_kind  = gpio_eip_pkg::KIND_CLEAR;
                    end
                    gpio_eip_pkg::OFF_RISE_SET: n_rise_trigger = r_rise_trigger | w_lane_data;
                    gpio_eip_pkg::OFF_RISE_CLR: n_rise_trigger = r_rise_trigger & ~w_lane_data;
                    gpio_eip_pkg::OFF_FALL_SET: n_fall_trigger = r_fall_trigger | w_lane_data;
                    gpio_eip_pkg::OFF_FALL_CLR: n_fall_trigger = r_fall_trigger & ~w_lane_data;
                    default: begin
                        n_unmapped = 1'b1;
                        w_update   = 1'b0;
                    end
                endcase
            end
            gpio_eip_pkg::MODE_PIN: begin
                w_update = 1'b1;
                n_external_levels[r_pin_index] = r_pin_level;
            end
            default: begin
                // unknown item kind: report levels only
            end
        endcase
    end

    // pin levels, change mask and edge detection on the updated state
    assign w_outputs    = ~n_direction;
    assign w_new_driven = n_output_value & w_outputs;
    assign w_new_pins   = w_new_driven | (n_external_levels & n_direction);
    assign w_rise       = w_new_pins & ~r_previous_pins & n_rise_trigger;
    assign w_fall       = ~w_new_pins & r_previous_pins & n_fall_trigger;

    always_comb begin
        n_read_data         = (w_read_value >> w_shift) & w_size_mask;
        n_driven_levels     = w_new_driven;
        n_pin_levels        = w_new_pins;
        n_previous_pins     = r_previous_pins;
        n_drive_change_mask = 32'h0;
        n_irq_pulse_mask    = 32'h0;
        if (w_update) begin
            n_previous_pins     = w_new_pins;
            n_drive_change_mask = ((w_new_driven ^ w_prior_driven) | (w_outputs & r_direction))
                                  & w_outputs;
            if (n_bank_irq_enable[0]) begin
                n_irq_pulse_mask = w_rise | w_fall;
            end
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_mode         <= i_mode;
            r_offset       <= i_offset;
            r_access_bytes <= i_access_bytes;
            r_write_data   <= i_write_data;
            r_pin_index    <= i_pin_index;
            r_pin_level    <= i_pin_level;
        end
    end

    // register state: commit when the item moves into the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_periph_ctrl     <= 32'h0;
            r_bank_irq_enable <= 32'h0;
            r_direction       <= 32'hFFFF_FFFF;
            r_output_value    <= 32'h0;
            r_rise_trigger    <= 32'h0;
            r_fall_trigger    <= 32'h0;
            r_external_levels <= 32'hFFFF_FFFF;
            r_previous_pins   <= 32'hFFFF_FFFF;
        end else if (w_advance) begin
            r_periph_ctrl     <= n_periph_ctrl;
            r_bank_irq_enable <= n_bank_irq_enable;
            r_direction       <= n_direction;
            r_output_value    <= n_output_value;
            r_rise_trigger    <= n_rise_trigger;
            r_fall_trigger    <= n_fall_trigger;
            r_external_levels <= n_external_levels;
            r_previous_pins   <= n_previous_pins;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_ready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_read_data         <= n_read_data;
            r_unmapped          <= n_unmapped;
            r_setclr_mask       <= n_setclr_mask;
            r_setclr_kind       <= n_setclr_kind;
            r_drive_change_mask <= n_drive_change_mask;
            r_driven_levels     <= n_driven_levels;
            r_irq_pulse_mask    <= n_irq_pulse_mask;
            r_pin_levels        <= n_pin_levels;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_read_data         = r_read_data;
    assign o_unmapped          = r_unmapped;
    assign o_setclr_mask       = r_setclr_mask;
    assign o_setclr_kind       = r_setclr_kind;
    assign o_drive_change_mask = r_drive_change_mask;
    assign o_driven_levels     = r_driven_levels;
    assign o_irq_pulse_mask    = r_irq_pulse_mask;
    assign o_pin_levels        = r_pin_levels;

`ifndef SYNTHESIS
    // an empty result register never holds off the input side
    a_no_stall_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> !o_in_stall)
        else $error("input stalled with empty result register");

    // no set/clear notice means no set/clear mask
    a_setclr_mask_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_setclr_kind == gpio_eip_pkg::KIND_NONE) |-> r_setclr_mask == 32'h0)
        else $error("set/clear mask without notice kind");

    // unmapped accesses run no update
    a_unmapped_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_unmapped)
        |-> (r_drive_change_mask == 32'h0 && r_irq_pulse_mask == 32'h0))
        else $error("unmapped access produced update results");

    // interrupt pulses only with bank enable set
    a_irq_needs_enable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_irq_pulse_mask != 32'h0) |-> r_bank_irq_enable[0])
        else $error("interrupt pulse with bank interrupts disabled");

    // change mask only names current output pins
    a_change_on_outputs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_drive_change_mask & r_direction) == 32'h0)
        else $error("drive change reported on an input pin");
`endif

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the GPIO edge interrupt port: bus reads, sub-word
// writes and pin events are pushed through the valid/stall handshake, and each
// result is compared against a cycle-free prediction of the register state.
// ----------------------------------------------------------------------------
module tb;

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 12;
    localparam int IDLE_PERCENT  = 9;
    localparam int HOLD_CYCLES   = 200;
    localparam int MAX_REPORTS   = 100;
    localparam int DRAIN_LIMIT   = 10000;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  offset;
        logic [2:0]  access_bytes;
        logic [31:0] write_data;
        logic [4:0]  pin_index;
        logic        pin_level;
    } t_gpio_item;

    typedef struct packed {
        logic [31:0] read_data;
        logic        unmapped;
        logic [31:0] setclr_mask;
        logic [1:0]  setclr_kind;
        logic [31:0] drive_change_mask;
        logic [31:0] driven_levels;
        logic [31:0] irq_pulse_mask;
        logic [31:0] pin_levels;
    } t_gpio_result;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_mode         = '0;
    logic [7:0]  i_offset       = '0;
    logic [2:0]  i_access_bytes = '0;
    logic [31:0] i_write_data   = '0;
    logic [4:0]  i_pin_index    = '0;
    logic        i_pin_level    = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall    = 1'b0;
    logic [31:0] o_read_data;
    logic        o_unmapped;
    logic [31:0] o_setclr_mask;
    logic [1:0]  o_setclr_kind;
    logic [31:0] o_drive_change_mask;
    logic [31:0] o_driven_levels;
    logic [31:0] o_irq_pulse_mask;
    logic [31:0] o_pin_levels;

    // shadow copy of the block's register state
    logic [31:0] shadow_periph;
    logic [31:0] shadow_bank_irq;
    logic [31:0] shadow_dir;
    logic [31:0] shadow_out;
    logic [31:0] shadow_rise;
    logic [31:0] shadow_fall;
    logic [31:0] shadow_ext;
    logic [31:0] shadow_prev;

    t_gpio_result expected_results[$];
    int           error_count  = 0;
    int           result_count = 0;
    logic         quiet        = 1'b0;
    logic         hold_token   = 1'b0;
    logic         hold_seen    = 1'b0;
    int           hold_left    = 0;

    gpio_edge_interrupt_port_unit dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_mode              (i_mode),
        .i_offset            (i_offset),
        .i_access_bytes      (i_access_bytes),
        .i_write_data        (i_write_data),
        .i_pin_index         (i_pin_index),
        .i_pin_level         (i_pin_level),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_read_data         (o_read_data),
        .o_unmapped          (o_unmapped),
        .o_setclr_mask       (o_setclr_mask),
        .o_setclr_kind       (o_setclr_kind),
        .o_drive_change_mask (o_drive_change_mask),
        .o_driven_levels     (o_driven_levels),
        .o_irq_pulse_mask    (o_irq_pulse_mask),
        .o_pin_levels        (o_pin_levels)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic logic [31:0] pin_view();
        return (shadow_out & ~shadow_dir) | (shadow_ext & shadow_dir);
    endfunction

    task automatic reset_shadow();
        shadow_periph   = '0;
        shadow_bank_irq = '0;
        shadow_dir      = '1;
        shadow_out      = '0;
        shadow_rise     = '0;
        shadow_fall     = '0;
        shadow_ext      = '1;
        shadow_prev     = pin_view();
    endtask

    // Apply one item to the shadow state and return the result it should give.
    function automatic t_gpio_result predict_gpio_step(input t_gpio_item it);
        t_gpio_result r;
        logic [31:0]  size_bits;
        logic [31:0]  lane_bits;
        logic [31:0]  placed;
        logic [31:0]  regval;
        logic [31:0]  prior_driven;
        logic [31:0]  old_dir;
        logic [31:0]  outputs;
        logic [31:0]  pins;
        logic [31:0]  rise;
        logic [31:0]  fall;
        logic [4:0]   shift;
        logic [7:0]   word_off;
        logic         update;
        r            = '0;
        regval       = '0;
        update       = 1'b0;
        shift        = {it.offset[1:0], 3'b000};
        word_off     = {it.offset[7:2], 2'b00};
        prior_driven = shadow_out & ~shadow_dir;
        old_dir      = shadow_dir;
        if (it.access_bytes == 3'd1) begin
            size_bits = 32'h0000_00FF;
        end else if (it.access_bytes == 3'd2) begin
            size_bits = 32'h0000_FFFF;
        end else begin
            size_bits = 32'hFFFF_FFFF;
        end
        // lanes past byte 3 fall off the top of the shift
        lane_bits = size_bits << shift;
        placed    = (it.write_data << shift) & lane_bits;
        case (it.mode)
            gpio_eip_pkg::MODE_READ: begin
                case (word_off)
                    gpio_eip_pkg::OFF_ID:       regval = gpio_eip_pkg::ID_VALUE;
                    gpio_eip_pkg::OFF_PERIPH:   regval = shadow_periph;
                    gpio_eip_pkg::OFF_BANK_IRQ: regval = shadow_bank_irq;
                    gpio_eip_pkg::OFF_DIR:      regval = shadow_dir;
                    gpio_eip_pkg::OFF_OUT,
                    gpio_eip_pkg::OFF_SET,
                    gpio_eip_pkg::OFF_CLR:      regval = shadow_out;
                    gpio_eip_pkg::OFF_PINS:     regval = pin_view();
                    gpio_eip_pkg::OFF_RISE_SET,
                    gpio_eip_pkg::OFF_RISE_CLR: regval = shadow_rise;
                    gpio_eip_pkg::OFF_FALL_SET,
                    gpio_eip_pkg::OFF_FALL_CLR: regval = shadow_fall;
                    default:                    r.unmapped = 1'b1;
                endcase
                r.read_data = (regval >> shift) & size_bits;
            end
            gpio_eip_pkg::MODE_WRITE: begin
                update = 1'b1;
                case (word_off)
                    gpio_eip_pkg::OFF_PERIPH: begin
                        shadow_periph = (shadow_periph & ~lane_bits) | placed;
                    end
                    gpio_eip_pkg::OFF_BANK_IRQ: begin
                        shadow_bank_irq = (shadow_bank_irq & ~lane_bits) | placed;
                    end
                    gpio_eip_pkg::OFF_DIR: shadow_dir = (shadow_dir & ~lane_bits) | placed;
                    gpio_eip_pkg::OFF_OUT: shadow_out = (shadow_out & ~lane_bits) | placed;
                    gpio_eip_pkg::OFF_SET: begin
                        shadow_out    = shadow_out | placed;
                        r.setclr_mask = placed;
                        r.setclr_kind = gpio_eip_pkg::KIND_SET;
                    end
                    gpio_eip_pkg::OFF_CLR: begin
                        shadow_out    = shadow_out & ~placed;
                        r.setclr_mask = placed;
                        r.setclr_kind = gpio_eip_pkg::KIND_CLEAR;
                    end
                    gpio_eip_pkg::OFF_RISE_SET: shadow_rise = shadow_rise | placed;
                    gpio_eip_pkg::OFF_RISE_CLR: shadow_rise = shadow_rise & ~placed;
                    gpio_eip_pkg::OFF_FALL_SET: shadow_fall = shadow_fall | placed;
                    gpio_eip_pkg::OFF_FALL_CLR: shadow_fall = shadow_fall & ~placed;
                    default: begin
                        update     = 1'b0;
                        r.unmapped = 1'b1;
                    end
                endcase
            end
            gpio_eip_pkg::MODE_PIN: begin
                shadow_ext[it.pin_index] = it.pin_level;
                update = 1'b1;
            end
            default: ;
        endcase
        if (update) begin
            outputs = ~shadow_dir;
            pins    = pin_view();
            rise    = pins & ~shadow_prev & shadow_rise;
            fall    = ~pins & shadow_prev & shadow_fall;
            r.drive_change_mask = (((shadow_out & outputs) ^ prior_driven)
                                   | (outputs & old_dir)) & outputs;
            r.irq_pulse_mask    = shadow_bank_irq[0] ? (rise | fall) : 32'h0;
            // previous pins follow every update, interrupts enabled or not
            shadow_prev = pins;
        end
        r.driven_levels = shadow_out & ~shadow_dir;
        r.pin_levels    = pin_view();
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("ERROR result %0d at %0t: %s", result_count, $time, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %08h want %08h", name, got, want));
    endtask

    // Offer one item and hold it until the transfer; called at a rising edge.
    task automatic send_item(input t_gpio_item it);
        while (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_mode         <= it.mode;
        i_offset       <= it.offset;
        i_access_bytes <= it.access_bytes;
        i_write_data   <= it.write_data;
        i_pin_index    <= it.pin_index;
        i_pin_level    <= it.pin_level;
        do @(posedge i_clk); while (o_in_stall);
        expected_results.push_back(predict_gpio_step(it));
    endtask

    task automatic reg_read(input logic [7:0] offset, input logic [2:0] nbytes);
        t_gpio_item it;
        it              = '0;
        it.mode         = gpio_eip_pkg::MODE_READ;
        it.offset       = offset;
        it.access_bytes = nbytes;
        send_item(it);
    endtask

    task automatic reg_write(input logic [7:0] offset, input logic [2:0] nbytes,
                             input logic [31:0] data);
        t_gpio_item it;
        it              = '0;
        it.mode         = gpio_eip_pkg::MODE_WRITE;
        it.offset       = offset;
        it.access_bytes = nbytes;
        it.write_data   = data;
        send_item(it);
    endtask

    task automatic pin_event(input logic [4:0] pin, input logic level);
        t_gpio_item it;
        it              = '0;
        it.mode         = gpio_eip_pkg::MODE_PIN;
        it.access_bytes = 3'd4;
        it.pin_index    = pin;
        it.pin_level    = level;
        send_item(it);
    endtask

    // Mostly mapped offsets; unused fields carry noise the block must ignore.
    function automatic t_gpio_item random_item();
        t_gpio_item it;
        int         pick;
        int         size_pick;
        it   = '0;
        pick = $urandom_range(99);
        if (pick < 30) begin
            it.mode = gpio_eip_pkg::MODE_READ;
        end else if (pick < 65) begin
            it.mode = gpio_eip_pkg::MODE_WRITE;
        end else begin
            it.mode = gpio_eip_pkg::MODE_PIN;
        end
        if ($urandom_range(3) == 0) begin
            it.offset = 8'($urandom_range(255));
        end else begin
            it.offset = 8'($urandom_range(8'h33));
        end
        size_pick = $urandom_range(19);
        if (size_pick == 0) begin
            it.access_bytes = 3'd3;
        end else if (size_pick < 7) begin
            it.access_bytes = 3'd1;
        end else if (size_pick < 13) begin
            it.access_bytes = 3'd2;
        end else begin
            it.access_bytes = 3'd4;
        end
        case ($urandom_range(9))
            0:       it.write_data = 32'h0000_0000;
            1:       it.write_data = 32'hFFFF_FFFF;
            default: it.write_data = $urandom;
        endcase
        it.pin_index = 5'($urandom_range(31));
        it.pin_level = 1'($urandom_range(1));
        return it;
    endfunction

    task automatic test_reset_values();
        reg_read(gpio_eip_pkg::OFF_ID, 3'd4);
        reg_read(gpio_eip_pkg::OFF_ID + 8'd3, 3'd1);
        reg_read(gpio_eip_pkg::OFF_ID + 8'd2, 3'd2);
        reg_read(gpio_eip_pkg::OFF_DIR, 3'd4);
        reg_read(gpio_eip_pkg::OFF_PINS, 3'd4);
        reg_read(8'h0C, 3'd4);
        reg_read(8'hFF, 3'd4);
    endtask

    task automatic test_register_access();
        reg_write(gpio_eip_pkg::OFF_DIR, 3'd2, 32'h0000_0000);
        reg_write(gpio_eip_pkg::OFF_OUT, 3'd4, 32'hFFFF_FFFF);
        reg_write(gpio_eip_pkg::OFF_SET + 8'd2, 3'd1, 32'hFFFF_FF5A);
        reg_write(gpio_eip_pkg::OFF_CLR, 3'd2, 32'h0000_00F0);
        // word access at lane 3 keeps only the top byte
        reg_write(gpio_eip_pkg::OFF_PERIPH + 8'd3, 3'd4, 32'hA5C3_9612);
        reg_read(gpio_eip_pkg::OFF_PERIPH, 3'd4);
        reg_write(gpio_eip_pkg::OFF_BANK_IRQ, 3'd3, 32'h0000_0001);
        reg_write(gpio_eip_pkg::OFF_RISE_SET, 3'd4, 32'hFFFF_FFFF);
        reg_write(gpio_eip_pkg::OFF_FALL_SET, 3'd4, 32'hFFFF_FFFF);
        reg_write(gpio_eip_pkg::OFF_ID, 3'd4, 32'hFFFF_FFFF);
        reg_write(gpio_eip_pkg::OFF_PINS + 8'd1, 3'd2, 32'h0000_1234);
        reg_write(8'h0C, 3'd1, 32'h0000_00FF);
        reg_write(8'hFC, 3'd4, 32'h0F0F_0F0F);
    endtask

    task automatic test_pin_edges();
        pin_event(5'd31, 1'b0);
        pin_event(5'd31, 1'b1);
        pin_event(5'd0, 1'b0);
        reg_write(gpio_eip_pkg::OFF_RISE_CLR, 3'd4, 32'hFFFF_FFFF);
        reg_write(gpio_eip_pkg::OFF_FALL_CLR + 8'd2, 3'd2, 32'hFFFF_FFFF);
        reg_read(gpio_eip_pkg::OFF_FALL_SET, 3'd4);
        reg_write(gpio_eip_pkg::OFF_BANK_IRQ, 3'd1, 32'h0000_0000);
        pin_event(5'd20, 1'b0);
        reg_read(gpio_eip_pkg::OFF_RISE_CLR, 3'd4);
    endtask

    task automatic test_back_to_back(input int count);
        quiet <= 1'b1;
        repeat (count) send_item(random_item());
        quiet <= 1'b0;
    endtask

    // The receiver holds off while the sender keeps offering, so the block fills.
    task automatic test_backpressure(input int count);
        hold_token <= ~hold_token;
        repeat (count) send_item(random_item());
    endtask

    task automatic test_random_traffic(input int count);
        repeat (count) send_item(random_item());
    endtask

    // Receiver: random stalls, plus a long hold-off when one is requested.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (hold_token != hold_seen) begin
            hold_seen   <= hold_token;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !quiet && ($urandom_range(99) < IDLE_PERCENT);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_gpio_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result transfer with nothing expected");
            end else begin
                want = expected_results.pop_front();
                check_field("read_data", o_read_data, want.read_data);
                check_field("unmapped", 32'(o_unmapped), 32'(want.unmapped));
                check_field("setclr_mask", o_setclr_mask, want.setclr_mask);
                check_field("setclr_kind", 32'(o_setclr_kind), 32'(want.setclr_kind));
                check_field("drive_change_mask", o_drive_change_mask,
                            want.drive_change_mask);
                check_field("driven_levels", o_driven_levels, want.driven_levels);
                check_field("irq_pulse_mask", o_irq_pulse_mask, want.irq_pulse_mask);
                check_field("pin_levels", o_pin_levels, want.pin_levels);
            end
            result_count++;
        end
    end

    initial begin
        int   wait_cycles;
        logic drained;
        reset_shadow();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_values();
        test_register_access();
        test_pin_edges();
        test_back_to_back(300);
        test_backpressure(40);
        test_random_traffic(1550);
        i_in_valid  <= 1'b0;
        wait_cycles = 0;
        while (expected_results.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        drained = (expected_results.size() == 0);
        if (drained)
            repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (drained && error_count == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb failed");
        $finish;
    end

endmodule
